// ----- rtl/dfop_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfop_pkg
// Shared types and constants of the DHCP frame option parser.
// ----------------------------------------------------------------------------
package dfop_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;

  localparam int unsigned POS_TYPE_HI = 12;
  localparam int unsigned POS_TYPE_LO = 13;
  localparam int unsigned POS_PROTO   = 23;
  localparam int unsigned POS_PORT_HI = 36;
  localparam int unsigned POS_PORT_LO = 37;
  localparam int unsigned POS_OPTIONS = 282;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'h11;
  localparam logic [15:0] UDP_PORT_SERV  = 16'd67;

  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_HOSTNAME = 8'd12;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_END      = 8'd255;

  localparam logic [7:0] MSG_DISCOVER = 8'd1;
  localparam logic [7:0] MSG_REQUEST  = 8'd3;

  typedef enum logic [1:0] {
    EV_OFFER = 2'd0,
    EV_ACK   = 2'd1,
    EV_NAME  = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic       valid;
    event_t     ev;
    logic [7:0] name_byte;
    logic       name_last;
  } result_t;

endpackage

// ----- rtl/dhcp_frame_option_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_frame_option_parser
// Parses DHCP options from a byte stream of Ethernet frames.
// ----------------------------------------------------------------------------
// Input channel in_*: one frame byte per request, in wire order; in_tlast
// marks the last byte of a frame. Headers are taken as fixed size, so DHCP
// options start at byte 282; frames that are not IPv4/UDP to port 67 give
// no results.
// Output channel out_*: zero or one result per input byte. An offer or ack
// event is raised by message type discover or request; hostname bytes follow
// one per request with out_tlast on the final byte of the option (or on the
// last byte of a truncated frame).
// An accepted byte's result is registered and appears on out_* in the next
// cycle. Throughput is one byte per cycle unless the receiver stalls, set
// by the single result register: in_tready is high whenever that register
// is empty or being drained. A stalled receiver holds the result register
// and in_tready drops until it is taken. Reset clears the frame position,
// header match and option state and empties the result register.
// ----------------------------------------------------------------------------
module dhcp_frame_option_parser #(
  parameter int unsigned MAX_FRAME_BYTES = dfop_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] frame_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] name_byte
  output logic [1:0] out_tuser,  // [1:0] event_res
  output logic       out_tlast
);

  logic              accept;
  logic              walk;
  dfop_pkg::result_t res;
  logic              out_valid_r;
  logic [1:0]        ev_r;
  logic [7:0]        name_r;
  logic              last_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  dfop_hdr #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .frame_byte(in_tdata),
    .frame_end (in_tlast),
    .walk      (walk)
  );

  dfop_opt u_opt (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .walk      (walk),
    .frame_byte(in_tdata),
    .frame_end (in_tlast),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= accept && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      ev_r   <= res.ev;
      name_r <= res.name_byte;
      last_r <= res.name_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = name_r;
  assign out_tuser  = ev_r;
  assign out_tlast  = last_r;

endmodule

// ----- rtl/dfop_hdr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfop_hdr
// Frame byte counter and Ethernet/IPv4/UDP header match.
// ----------------------------------------------------------------------------
module dfop_hdr #(
  parameter int unsigned MAX_FRAME_BYTES = dfop_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] frame_byte,
  input  logic       frame_end,
  output logic       walk
);

  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             match_r, match_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic             in_range;
  logic             in_hdr;

  assign in_range = pos_r < POS_W'(MAX_FRAME_BYTES);
  assign in_hdr   = pos_r < POS_W'(dfop_pkg::POS_OPTIONS);
  assign walk     = in_range && !in_hdr && match_r;

  always_comb begin
    pos_nxt   = pos_r;
    match_nxt = match_r;
    hi_nxt    = hi_r;
    if (in_range) begin
      pos_nxt = pos_r + POS_W'(1);
      if (in_hdr) begin
        if (pos_r == POS_W'(dfop_pkg::POS_TYPE_HI) ||
            pos_r == POS_W'(dfop_pkg::POS_PORT_HI)) begin
          hi_nxt = frame_byte;
        end else if (pos_r == POS_W'(dfop_pkg::POS_TYPE_LO)) begin
          if ({hi_r, frame_byte} != dfop_pkg::ETHERTYPE_IPV4) match_nxt = 1'b0;
        end else if (pos_r == POS_W'(dfop_pkg::POS_PROTO)) begin
          if (frame_byte != dfop_pkg::IP_PROTO_UDP) match_nxt = 1'b0;
        end else if (pos_r == POS_W'(dfop_pkg::POS_PORT_LO)) begin
          if ({hi_r, frame_byte} != dfop_pkg::UDP_PORT_SERV) match_nxt = 1'b0;
        end
      end
    end
    if (frame_end) begin
      pos_nxt   = '0;
      match_nxt = 1'b1;
      hi_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      match_r <= 1'b1;
      hi_r    <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      match_r <= match_nxt;
      hi_r    <= hi_nxt;
    end
  end

endmodule

// ----- rtl/dfop_opt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfop_opt
// DHCP option list walker: message type events and hostname bytes.
// ----------------------------------------------------------------------------
module dfop_opt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              walk,
  input  logic [7:0]        frame_byte,
  input  logic              frame_end,
  output dfop_pkg::result_t res
);

  dfop_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       code_r, code_nxt;
  logic [7:0]       left_r, left_nxt;
  logic             first_r, first_nxt;

  always_comb begin
    phase_nxt     = phase_r;
    code_nxt      = code_r;
    left_nxt      = left_r;
    first_nxt     = first_r;
    res.valid     = 1'b0;
    res.ev        = dfop_pkg::EV_OFFER;
    res.name_byte = '0;
    res.name_last = 1'b0;
    if (walk) begin
      unique case (phase_r)
        dfop_pkg::PH_TYPE: begin
          if (frame_byte == dfop_pkg::OPT_END) begin
            phase_nxt = dfop_pkg::PH_DONE;
          end else if (frame_byte != dfop_pkg::OPT_PAD) begin
            code_nxt  = frame_byte;
            phase_nxt = dfop_pkg::PH_LEN;
          end
        end
        dfop_pkg::PH_LEN: begin
          left_nxt  = frame_byte;
          first_nxt = 1'b1;
          phase_nxt = (frame_byte == 8'd0) ? dfop_pkg::PH_TYPE : dfop_pkg::PH_VALUE;
        end
        dfop_pkg::PH_VALUE: begin
          if (code_r == dfop_pkg::OPT_MSG_TYPE && first_r) begin
            if (frame_byte == dfop_pkg::MSG_DISCOVER) begin
              res.valid = 1'b1;
              res.ev    = dfop_pkg::EV_OFFER;
            end else if (frame_byte == dfop_pkg::MSG_REQUEST) begin
              res.valid = 1'b1;
              res.ev    = dfop_pkg::EV_ACK;
            end
          end else if (code_r == dfop_pkg::OPT_HOSTNAME) begin
            res.valid     = 1'b1;
            res.ev        = dfop_pkg::EV_NAME;
            res.name_byte = frame_byte;
            res.name_last = (left_r == 8'd1) || frame_end;
          end
          first_nxt = 1'b0;
          left_nxt  = left_r - 8'd1;
          if (left_nxt == 8'd0) phase_nxt = dfop_pkg::PH_TYPE;
        end
        dfop_pkg::PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
    if (frame_end) begin
      phase_nxt = dfop_pkg::PH_TYPE;
      code_nxt  = '0;
      left_nxt  = '0;
      first_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dfop_pkg::PH_TYPE;
      code_r  <= '0;
      left_r  <= '0;
      first_r <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
      left_r  <= left_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

// ----- rtl/dfop_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfop_chk
// Port checks of the DHCP frame option parser, bound to the top level.
// ----------------------------------------------------------------------------
module dfop_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_rst_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result present after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == dfop_pkg::EV_OFFER) || (out_tuser == dfop_pkg::EV_ACK) ||
                   (out_tuser == dfop_pkg::EV_NAME))
    else $error("bad event code");

  a_event_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != dfop_pkg::EV_NAME) |->
      (out_tdata == 8'd0) && !out_tlast)
    else $error("reply event carries hostname data");

endmodule

bind dhcp_frame_option_parser dfop_chk u_dfop_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DHCP frame option parser.
// Ethernet frames go in one byte per request: a frame packed with directed
// option cases, one with a faulty header, two cut short inside the option
// list, and a few short noise frames. A local parser model predicts each
// offer, ack and hostname event, and the monitor checks every event in order
// against it. The run goes through four pacing phases, with one long receiver
// hold-off in the first phase and a full drain after each phase.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned FRAME_CAP   = dfop_pkg::MAX_FRAME_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT = 60000;
  localparam int unsigned LONG_HOLD   = 600;
  localparam logic [7:0]  OPT_FILLER  = 8'd99;

  typedef enum int unsigned {
    FAULT_NONE,
    FAULT_TYPE_HI,
    FAULT_TYPE_LO,
    FAULT_PROTO,
    FAULT_PORT_HI,
    FAULT_PORT_LO
  } hdr_fault_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  typedef struct packed {
    dfop_pkg::event_t ev;
    logic [7:0]       name_byte;
    logic             name_last;
  } dhcp_event_t;

  typedef struct packed {
    logic [15:0]      pos;
    logic             hdr_ok;
    logic [7:0]       hi_byte;
    dfop_pkg::phase_t phase;
    logic [7:0]       code;
    logic [7:0]       left;
    logic             first;
  } parse_state_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] frame_byte
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] name_byte
  logic [1:0] out_tuser;           // [1:0] event_res
  logic       out_tlast;

  frame_byte_t  byte_requests[$];
  dhcp_event_t  expected_events[$];
  logic [7:0]   frame_buf[$];
  parse_state_t check_state;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_ask       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatches     = 0;
  int unsigned events_checked = 0;
  int unsigned bytes_accepted = 0;
  int unsigned frames_sent    = 0;

  dhcp_frame_option_parser #(
    .MAX_FRAME_BYTES(FRAME_CAP)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic parse_state_t fresh_frame();
    parse_state_t s;
    s.pos     = '0;
    s.hdr_ok  = 1'b1;
    s.hi_byte = '0;
    s.phase   = dfop_pkg::PH_TYPE;
    s.code    = '0;
    s.left    = '0;
    s.first   = 1'b0;
    return s;
  endfunction

  function automatic void parse_byte(inout parse_state_t s, input logic [7:0] b,
                                     input logic fe, output logic hit,
                                     output dhcp_event_t r);
    hit         = 1'b0;
    r.ev        = dfop_pkg::EV_OFFER;
    r.name_byte = 8'h00;
    r.name_last = 1'b0;
    if (s.pos < FRAME_CAP) begin
      if (s.pos < dfop_pkg::POS_OPTIONS) begin
        case (s.pos)
          dfop_pkg::POS_TYPE_HI, dfop_pkg::POS_PORT_HI: begin
            s.hi_byte = b;
          end
          dfop_pkg::POS_TYPE_LO: begin
            if ({s.hi_byte, b} != dfop_pkg::ETHERTYPE_IPV4) s.hdr_ok = 1'b0;
          end
          dfop_pkg::POS_PROTO: begin
            if (b != dfop_pkg::IP_PROTO_UDP) s.hdr_ok = 1'b0;
          end
          dfop_pkg::POS_PORT_LO: begin
            if ({s.hi_byte, b} != dfop_pkg::UDP_PORT_SERV) s.hdr_ok = 1'b0;
          end
          default: ;
        endcase
      end else if (s.hdr_ok) begin
        case (s.phase)
          dfop_pkg::PH_TYPE: begin
            if (b == dfop_pkg::OPT_END) begin
              s.phase = dfop_pkg::PH_DONE;
            end else if (b != dfop_pkg::OPT_PAD) begin
              s.code  = b;
              s.phase = dfop_pkg::PH_LEN;
            end
          end
          dfop_pkg::PH_LEN: begin
            s.left  = b;
            s.first = 1'b1;
            s.phase = (b == 8'd0) ? dfop_pkg::PH_TYPE : dfop_pkg::PH_VALUE;
          end
          dfop_pkg::PH_VALUE: begin
            if (s.code == dfop_pkg::OPT_MSG_TYPE && s.first) begin
              if (b == dfop_pkg::MSG_DISCOVER || b == dfop_pkg::MSG_REQUEST) begin
                hit  = 1'b1;
                r.ev = (b == dfop_pkg::MSG_DISCOVER) ? dfop_pkg::EV_OFFER : dfop_pkg::EV_ACK;
              end
            end else if (s.code == dfop_pkg::OPT_HOSTNAME) begin
              hit         = 1'b1;
              r.ev        = dfop_pkg::EV_NAME;
              r.name_byte = b;
              r.name_last = (s.left == 8'd1) || fe;
            end
            s.first = 1'b0;
            s.left  = s.left - 8'd1;
            if (s.left == 8'd0) s.phase = dfop_pkg::PH_TYPE;
          end
          default: ;
        endcase
      end
      s.pos = s.pos + 16'd1;
    end
    if (fe) s = fresh_frame();
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic start_frame(input hdr_fault_t fault);
    logic [7:0] flip;
    frame_buf.delete();
    repeat (dfop_pkg::POS_OPTIONS) frame_buf.push_back(8'($urandom));
    frame_buf[dfop_pkg::POS_TYPE_HI] = dfop_pkg::ETHERTYPE_IPV4[15:8];
    frame_buf[dfop_pkg::POS_TYPE_LO] = dfop_pkg::ETHERTYPE_IPV4[7:0];
    frame_buf[dfop_pkg::POS_PROTO]   = dfop_pkg::IP_PROTO_UDP;
    frame_buf[dfop_pkg::POS_PORT_HI] = dfop_pkg::UDP_PORT_SERV[15:8];
    frame_buf[dfop_pkg::POS_PORT_LO] = dfop_pkg::UDP_PORT_SERV[7:0];
    flip = 8'($urandom_range(1, 255));
    case (fault)
      FAULT_TYPE_HI: frame_buf[dfop_pkg::POS_TYPE_HI] ^= flip;
      FAULT_TYPE_LO: frame_buf[dfop_pkg::POS_TYPE_LO] ^= flip;
      FAULT_PROTO:   frame_buf[dfop_pkg::POS_PROTO]   ^= flip;
      FAULT_PORT_HI: frame_buf[dfop_pkg::POS_PORT_HI] ^= flip;
      FAULT_PORT_LO: frame_buf[dfop_pkg::POS_PORT_LO] ^= flip;
      default: ;
    endcase
  endtask

  task automatic put_option(input logic [7:0] code, input logic [7:0] len,
                            input logic [7:0] first);
    frame_buf.push_back(code);
    frame_buf.push_back(len);
    if (len != 8'd0) begin
      frame_buf.push_back(first);
      repeat (int'(len) - 1) frame_buf.push_back(8'($urandom));
    end
  endtask

  task automatic put_random_options();
    int unsigned pick;
    logic [7:0]  code;
    logic [7:0]  msg;
    repeat ($urandom_range(2, 6)) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        frame_buf.push_back(dfop_pkg::OPT_PAD);
      end else if (pick < 35) begin
        case ($urandom_range(2))
          0:       msg = dfop_pkg::MSG_DISCOVER;
          1:       msg = dfop_pkg::MSG_REQUEST;
          default: msg = 8'($urandom);
        endcase
        put_option(dfop_pkg::OPT_MSG_TYPE, 8'($urandom_range(0, 3)), msg);
      end else if (pick < 75) begin
        put_option(dfop_pkg::OPT_HOSTNAME, 8'($urandom_range(0, 12)), 8'($urandom));
      end else begin
        code = 8'($urandom_range(1, 254));
        if (code == dfop_pkg::OPT_HOSTNAME || code == dfop_pkg::OPT_MSG_TYPE)
          code = OPT_FILLER;
        put_option(code, 8'($urandom_range(0, 8)), 8'($urandom));
      end
    end
  endtask

  task automatic send_frame();
    frame_byte_t item;
    for (int i = 0; i < frame_buf.size(); i++) begin
      item.data = frame_buf[i];
      item.last = (i == frame_buf.size() - 1);
      byte_requests.push_back(item);
    end
    frames_sent++;
  endtask

  task automatic send_noise_frame();
    frame_buf.delete();
    repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom));
    send_frame();
  endtask

  // reply events, odd option lengths, pads, empty options, bytes past the end
  task automatic send_directed_frames();
    start_frame(FAULT_NONE);
    put_option(OPT_FILLER, 8'd2, dfop_pkg::OPT_END);
    put_option(dfop_pkg::OPT_MSG_TYPE, 8'd1, dfop_pkg::MSG_DISCOVER);
    frame_buf.push_back(dfop_pkg::OPT_PAD);
    frame_buf.push_back(dfop_pkg::OPT_PAD);
    put_option(dfop_pkg::OPT_MSG_TYPE, 8'd0, 8'd0);
    put_option(dfop_pkg::OPT_HOSTNAME, 8'd0, 8'd0);
    put_option(dfop_pkg::OPT_MSG_TYPE, 8'd3, 8'd2);
    put_option(dfop_pkg::OPT_HOSTNAME, 8'd1, 8'h00);
    put_option(dfop_pkg::OPT_HOSTNAME, 8'd1, 8'hff);
    put_option(dfop_pkg::OPT_HOSTNAME, 8'd6, 8'h41);
    put_option(dfop_pkg::OPT_MSG_TYPE, 8'd1, dfop_pkg::MSG_REQUEST);
    frame_buf.push_back(dfop_pkg::OPT_END);
    put_option(dfop_pkg::OPT_HOSTNAME, 8'd3, 8'h78);
    send_frame();

    frame_buf.delete();
    frame_buf.push_back(8'hff);
    send_frame();
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    send_frame();
    send_noise_frame();
  endtask

  // options behind a broken header are ignored
  task automatic send_fault_frame();
    start_frame(hdr_fault_t'($urandom_range(1, 5)));
    put_option(dfop_pkg::OPT_MSG_TYPE, 8'd1, dfop_pkg::MSG_DISCOVER);
    put_option(dfop_pkg::OPT_HOSTNAME, 8'd3, 8'h6e);
    frame_buf.push_back(dfop_pkg::OPT_END);
    send_frame();
    send_noise_frame();
  endtask

  // frame cut inside a hostname value
  task automatic send_cut_hostname_frame();
    start_frame(FAULT_NONE);
    put_option(dfop_pkg::OPT_MSG_TYPE, 8'd1, dfop_pkg::MSG_REQUEST);
    put_random_options();
    put_option(dfop_pkg::OPT_HOSTNAME, 8'd10, 8'h68);
    repeat (4) void'(frame_buf.pop_back());
    send_frame();
  endtask

  // frame cut on a length byte
  task automatic send_cut_length_frame();
    start_frame(FAULT_NONE);
    put_random_options();
    put_option(dfop_pkg::OPT_HOSTNAME, 8'd4, 8'h6e);
    put_option(dfop_pkg::OPT_MSG_TYPE, 8'd2, dfop_pkg::MSG_DISCOVER);
    put_random_options();
    frame_buf.push_back(dfop_pkg::OPT_HOSTNAME);
    frame_buf.push_back(8'd5);
    send_frame();
  endtask

  task automatic wait_drain();
    while (byte_requests.size() != 0 || in_tvalid || expected_events.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(posedge clk) begin : byte_driver
    frame_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tlast  <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (byte_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.data;
        in_tlast  <= nxt.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : event_sink
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_seen != hold_ask) begin
      hold_seen  <= hold_ask;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check the event leaving first, then predict from the request entering
  always @(posedge clk) begin : scoreboard
    dhcp_event_t want;
    dhcp_event_t ev;
    logic        hit;
    if (rst_n && out_tvalid && out_tready) begin
      events_checked++;
      if (expected_events.size() == 0) begin
        log_mismatch($sformatf("unexpected event, tuser %h tdata %h tlast %b",
                               out_tuser, out_tdata, out_tlast));
      end else begin
        want = expected_events.pop_front();
        if (out_tuser != want.ev || out_tdata != want.name_byte ||
            out_tlast != want.name_last)
          log_mismatch($sformatf(
            "expected ev %0d byte %h last %b, got ev %0d byte %h last %b",
            want.ev, want.name_byte, want.name_last,
            out_tuser, out_tdata, out_tlast));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      bytes_accepted++;
      parse_byte(check_state, in_tdata, in_tlast, hit, ev);
      if (hit) expected_events.push_back(ev);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events outstanding",
               cycle_count, expected_events.size());
      $display("tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    check_state = fresh_frame();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      case (p)
        0: begin
          hold_ask++;
          send_directed_frames();
        end
        1:       send_fault_frame();
        2:       send_cut_hostname_frame();
        default: send_cut_length_frame();
      endcase
      wait_drain();
    end
    repeat (8) @(negedge clk);
    if (expected_events.size() != 0)
      log_mismatch($sformatf("%0d events never arrived", expected_events.size()));
    $display("run: %0d frames, %0d bytes, %0d events checked, %0d mismatches, %0d cycles",
             frames_sent, bytes_accepted, events_checked, mismatches, cycle_count);
    $display("run: reply and hostname options, a broken header, cut frames, four pacings");
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dfop_pkg.sv
rtl/dfop_hdr.sv
rtl/dfop_opt.sv
rtl/dhcp_frame_option_parser.sv
rtl/dfop_chk.sv
verif/tb.sv
